// ===== rtl/sgs_pkg.sv =====
// Shared types and constants of the Sobel gradient stream unit.
// No dependencies; every other file of the unit imports this package.
package sgs_pkg;

    // Direction codes of a gradient
    typedef enum logic [1:0] {
        DIR_HORIZONTAL    = 2'd0,
        DIR_DIAG_SAME     = 2'd1,
        DIR_VERTICAL      = 2'd2,
        DIR_DIAG_OPPOSITE = 2'd3
    } dir_t;

    // Configuration register indexes
    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam int unsigned MIN_DIM      = 3;
    localparam int unsigned RESET_WIDTH  = 640;
    localparam int unsigned RESET_HEIGHT = 480;

    // gray = (r + g + b) / 3 as (sum * 683) >> 11, exact for sums up to 765
    localparam logic [9:0] GRAY_RECIP = 10'd683;
    localparam int         GRAY_SHIFT = 11;

    // tan(22/23/67/68 degrees) in unsigned Q32, rounded to nearest
    localparam logic [33:0] TAN22_Q32 = 34'd1735279427;
    localparam logic [33:0] TAN23_Q32 = 34'd1823105454;
    localparam logic [33:0] TAN67_Q32 = 34'd10118308865;
    localparam logic [33:0] TAN68_Q32 = 34'd10630417090;

    localparam int PROD_W = 44;

    // Result queue sizing
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = 3;
    localparam int QCNT_W      = 4;
    localparam int MAX_RESULTS = 3;

    // Which results a pixel causes, and where they sit in the frame
    typedef struct packed {
        logic        interior;
        logic        gradient;
        logic        row_end;
        logic        last_row;
        logic [11:0] row_cur;
        logic [11:0] row_prev;
        logic [9:0]  col_cur;
        logic [9:0]  col_prev;
    } tag_t;

    typedef struct packed {
        logic [20:0] magnitude_sq;
        dir_t        direction;
        logic [11:0] out_row;
        logic [9:0]  out_col;
        logic        last;
    } result_t;

endpackage

// ===== rtl/sgs_line_window.sv =====
// Line stores, 3x3 window and Sobel gx/gy of the gradient stream unit.
// Depends on sgs_pkg for the gray conversion constants.
module sgs_line_window #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic                         s1_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0] s1_col,
    input  logic [9:0]                   s1_sum,
    output logic signed [10:0]           gx,
    output logic signed [10:0]           gy
);
    import sgs_pkg::*;

    logic [7:0] upper_mem [MAX_WIDTH];
    logic [7:0] middle_mem [MAX_WIDTH];
    logic [7:0] upper_rd_reg;
    logic [7:0] middle_rd_reg;
    logic [7:0] win_reg [6];
    logic [19:0] gray_prod;
    logic [7:0]  bot;
    logic [9:0]  gx_pos, gx_neg, gy_pos, gy_neg;
    logic signed [11:0] gx_full, gy_full;
    logic signed [10:0] gx_reg, gy_reg;
    logic               shift_en;

    assign shift_en  = adv && s1_valid;
    assign gray_prod = 20'(s1_sum) * 20'(GRAY_RECIP);
    assign bot       = gray_prod[GRAY_SHIFT +: 8];

    // Line stores: read for the pixel entering, write for the pixel in the window stage
    always_ff @(posedge aclk) begin
        if (adv) begin
            upper_rd_reg  <= upper_mem[rd_addr];
            middle_rd_reg <= middle_mem[rd_addr];
        end
        if (shift_en) begin
            upper_mem[s1_col]  <= middle_rd_reg;
            middle_mem[s1_col] <= bot;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (shift_en) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= upper_rd_reg;
            win_reg[4] <= middle_rd_reg;
            win_reg[5] <= bot;
        end
    end

    always_comb begin
        gx_pos  = 10'(upper_rd_reg) + {1'b0, middle_rd_reg, 1'b0} + 10'(bot);
        gx_neg  = 10'(win_reg[0]) + {1'b0, win_reg[1], 1'b0} + 10'(win_reg[2]);
        gy_pos  = 10'(win_reg[2]) + {1'b0, win_reg[5], 1'b0} + 10'(bot);
        gy_neg  = 10'(win_reg[0]) + {1'b0, win_reg[3], 1'b0} + 10'(upper_rd_reg);
        gx_full = signed'({2'b00, gx_pos}) - signed'({2'b00, gx_neg});
        gy_full = signed'({2'b00, gy_pos}) - signed'({2'b00, gy_neg});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            gx_reg <= gx_full[10:0];
            gy_reg <= gy_full[10:0];
        end
    end

    assign gx = gx_reg;
    assign gy = gy_reg;

endmodule

// ===== rtl/sgs_grad_stage.sv =====
// Squared magnitude and direction code of a Sobel gradient.
// Depends on sgs_pkg for the tangent constants and direction codes.
module sgs_grad_stage (
    input  logic               aclk,
    input  logic               adv,
    input  logic signed [10:0] gx,
    input  logic signed [10:0] gy,
    output logic [20:0]        magnitude_sq,
    output sgs_pkg::dir_t      direction
);
    import sgs_pkg::*;

    logic [10:0] gx_abs, gy_abs;
    logic [9:0]  ax, ay;
    logic [19:0] sqx_reg, sqy_reg;
    logic [PROD_W-1:0] p22_reg, p23_reg, p67_reg, p68_reg;
    logic [9:0]  ay_reg;
    logic        gx_pos_reg, gy_pos_reg, ax_zero_reg, ay_zero_reg;
    logic [PROD_W-1:0] lhs;
    dir_t        diag;

    always_comb begin
        gx_abs = gx[10] ? 11'(-gx) : 11'(gx);
        gy_abs = gy[10] ? 11'(-gy) : 11'(gy);
        ax     = gx_abs[9:0];
        ay     = gy_abs[9:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sqx_reg     <= 20'(ax) * 20'(ax);
            sqy_reg     <= 20'(ay) * 20'(ay);
            p22_reg     <= PROD_W'(TAN22_Q32) * PROD_W'(ax);
            p23_reg     <= PROD_W'(TAN23_Q32) * PROD_W'(ax);
            p67_reg     <= PROD_W'(TAN67_Q32) * PROD_W'(ax);
            p68_reg     <= PROD_W'(TAN68_Q32) * PROD_W'(ax);
            ay_reg      <= ay;
            gx_pos_reg  <= !gx[10] && (gx != 11'sd0);
            gy_pos_reg  <= !gy[10] && (gy != 11'sd0);
            ax_zero_reg <= (ax == 10'd0);
            ay_zero_reg <= (ay == 10'd0);
        end
    end

    assign lhs          = {2'b00, ay_reg, 32'd0};
    assign magnitude_sq = 21'(sqx_reg) + 21'(sqy_reg);
    assign diag         = (gx_pos_reg == gy_pos_reg) ? DIR_DIAG_SAME : DIR_DIAG_OPPOSITE;

    // Positive gx uses strict bounds at 23/68 degrees, negative gx inclusive ones at 22/67
    always_comb begin
        if (ax_zero_reg) begin
            direction = ay_zero_reg ? DIR_HORIZONTAL : DIR_VERTICAL;
        end else if (gx_pos_reg) begin
            if (lhs < p23_reg) begin
                direction = DIR_HORIZONTAL;
            end else if (lhs < p68_reg) begin
                direction = diag;
            end else begin
                direction = DIR_VERTICAL;
            end
        end else begin
            if (lhs <= p22_reg) begin
                direction = DIR_HORIZONTAL;
            end else if (lhs <= p67_reg) begin
                direction = diag;
            end else begin
                direction = DIR_VERTICAL;
            end
        end
    end

endmodule

// ===== rtl/sgs_result_queue.sv =====
// Result queue: takes up to three results per cycle, hands out one per cycle on pop.
// Depends on sgs_pkg for the result type and queue sizing.
module sgs_result_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_en,
    input  logic [1:0]        push_cnt,
    input  sgs_pkg::result_t  push_items [3],
    input  logic              pop,
    output logic              space_ok,
    output logic              not_empty,
    output sgs_pkg::result_t  head_item
);
    import sgs_pkg::*;

    result_t             q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   head_reg, head_next;
    logic [QPTR_W-1:0]   tail_reg, tail_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic [1:0]          push_n;

    assign push_n = push_en ? push_cnt : 2'd0;

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (2'(k) < push_n) begin
                q_mem[QPTR_W'(tail_reg + QPTR_W'(k))] <= push_items[k];
            end
        end
    end

    always_comb begin
        tail_next  = tail_reg + QPTR_W'(push_n);
        head_next  = pop ? QPTR_W'(head_reg + QPTR_W'(1)) : head_reg;
        count_next = count_reg + QCNT_W'(push_n) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Room for a full burst of results from the last pipeline stage
    assign space_ok  = (count_reg <= QCNT_W'(QUEUE_DEPTH - MAX_RESULTS));
    assign not_empty = (count_reg != '0);
    assign head_item = q_mem[head_reg];

endmodule

// ===== rtl/sobel_gradient_stream_unit.sv =====
// Sobel gradient stream unit: RGB raster pixels in, squared magnitude and direction out.
// Accepted pixels pass the input, gx/gy and product registers; their results then enter the result queue.
// Throughput: one pixel per clock while the queue has room; row ends give two results
// and last-row pixels one to three, so the one-result-per-cycle output throttles s_tready.
// Reset clears position counters, window and result queue and sets 640 x 480;
// line stores are not cleared.
module sobel_gradient_stream_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    // pixel requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // magnitude_sq[20:0], direction[22:21],
                                   // out_row[34:23], out_col[44:35], zero[47:45]
    output logic        m_tlast
);
    import sgs_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        int unsigned res;
        res = v;
        if (v < MIN_DIM) begin
            res = MIN_DIM;
        end else if (v > hi) begin
            res = hi;
        end
        return res;
    endfunction

    localparam logic [CW-1:0] RESET_W_LAST = CW'(clamp_dim(RESET_WIDTH, MAX_WIDTH) - 1);
    localparam logic [RW-1:0] RESET_H_LAST = RW'(clamp_dim(RESET_HEIGHT, MAX_HEIGHT) - 1);

    logic [CW-1:0] w_last_reg, w_last_next;
    logic [RW-1:0] h_last_reg, h_last_next;
    logic [CW-1:0] col_count_reg, col_count_next;
    logic [RW-1:0] row_count_reg, row_count_next;

    logic          adv;
    logic          s_accept;
    tag_t          in_tag;

    logic          s1_valid_reg, s2_valid_reg, s3_valid_reg;
    tag_t          s1_tag_reg, s2_tag_reg, s3_tag_reg;
    logic [CW-1:0] s1_col_reg;
    logic [9:0]    s1_sum_reg;

    logic signed [10:0] gx, gy;
    logic [20:0]   grad_mag;
    dir_t          grad_dir;

    result_t       push_items [3];
    logic [1:0]    push_cnt;
    logic          space_ok;
    result_t       head_item;

    assign adv       = space_ok;
    assign s_tready  = adv;
    assign s_accept  = s_tvalid && adv;
    assign cfg_ready = 1'b1;

    // Position of the incoming pixel and the results it causes
    always_comb begin
        in_tag          = '0;
        in_tag.interior = (row_count_reg != '0) && (col_count_reg != '0);
        in_tag.gradient = (row_count_reg > RW'(1)) && (col_count_reg > CW'(1));
        in_tag.row_end  = (row_count_reg != '0) && (col_count_reg == w_last_reg);
        in_tag.last_row = (row_count_reg == h_last_reg);
        in_tag.row_cur  = 12'(row_count_reg);
        in_tag.row_prev = 12'(row_count_reg) - 12'd1;
        in_tag.col_cur  = 10'(col_count_reg);
        in_tag.col_prev = 10'(col_count_reg) - 10'd1;
    end

    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        w_last_next    = w_last_reg;
        h_last_next    = h_last_reg;
        if (s_accept) begin
            if (col_count_reg == w_last_reg) begin
                col_count_next = '0;
                row_count_next = (row_count_reg == h_last_reg) ? '0 :
                                 RW'(row_count_reg + RW'(1));
            end else begin
                col_count_next = CW'(col_count_reg + CW'(1));
            end
        end
        // A register write restarts the frame
        if (cfg_valid) begin
            case (cfg_index)
                REG_FRAME_WIDTH: begin
                    w_last_next = CW'(clamp_dim(32'(cfg_data[10:0]), MAX_WIDTH) - 1);
                end
                REG_FRAME_HEIGHT: begin
                    h_last_next = RW'(clamp_dim(32'(cfg_data), MAX_HEIGHT) - 1);
                end
                default: begin
                end
            endcase
            col_count_next = '0;
            row_count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg    <= RESET_W_LAST;
            h_last_reg    <= RESET_H_LAST;
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else begin
            w_last_reg    <= w_last_next;
            h_last_reg    <= h_last_next;
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // Pipeline control: input register, gx/gy register, product register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_tag_reg <= in_tag;
            s1_col_reg <= col_count_reg;
            s1_sum_reg <= 10'(s_tdata[7:0]) + 10'(s_tdata[15:8]) + 10'(s_tdata[23:16]);
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    sgs_line_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .rd_addr  (col_count_reg),
        .s1_valid (s1_valid_reg),
        .s1_col   (s1_col_reg),
        .s1_sum   (s1_sum_reg),
        .gx       (gx),
        .gy       (gy)
    );

    sgs_grad_stage u_grad (
        .aclk         (aclk),
        .adv          (adv),
        .gx           (gx),
        .gy           (gy),
        .magnitude_sq (grad_mag),
        .direction    (grad_dir)
    );

    // Gather the results of the pixel leaving the pipeline in output order
    always_comb begin
        push_cnt = 2'd0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            push_items[k] = '0;
        end
        if (s3_valid_reg) begin
            if (s3_tag_reg.interior) begin
                push_items[push_cnt].magnitude_sq = s3_tag_reg.gradient ? grad_mag : '0;
                push_items[push_cnt].direction    = s3_tag_reg.gradient ? grad_dir :
                                                    DIR_HORIZONTAL;
                push_items[push_cnt].out_row      = s3_tag_reg.row_prev;
                push_items[push_cnt].out_col      = s3_tag_reg.col_prev;
                push_cnt = push_cnt + 2'd1;
            end
            if (s3_tag_reg.row_end) begin
                push_items[push_cnt].direction = DIR_HORIZONTAL;
                push_items[push_cnt].out_row   = s3_tag_reg.row_prev;
                push_items[push_cnt].out_col   = s3_tag_reg.col_cur;
                push_cnt = push_cnt + 2'd1;
            end
            if (s3_tag_reg.last_row) begin
                push_items[push_cnt].direction = DIR_HORIZONTAL;
                push_items[push_cnt].out_row   = s3_tag_reg.row_cur;
                push_items[push_cnt].out_col   = s3_tag_reg.col_cur;
                push_cnt = push_cnt + 2'd1;
            end
        end
        if (push_cnt != 2'd0) begin
            push_items[push_cnt - 2'd1].last = 1'b1;
        end
    end

    sgs_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_en    (adv),
        .push_cnt   (push_cnt),
        .push_items (push_items),
        .pop        (m_tvalid && m_tready),
        .space_ok   (space_ok),
        .not_empty  (m_tvalid),
        .head_item  (head_item)
    );

    assign m_tdata = {3'b000, head_item.out_col, head_item.out_row,
                      head_item.direction, head_item.magnitude_sq};
    assign m_tlast = head_item.last;

endmodule

// ===== tb/sgs_checker.sv =====
// Result checker for the Sobel gradient stream unit: watches the register, pixel and
// result channels, predicts every result and compares it field by field.
// Depends on sgs_pkg for the direction codes, register indexes and result layout.
`timescale 1ns / 100ps
module sgs_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          pending_results
);
    import sgs_pkg::*;

    localparam int unsigned FRAME_MAX_COLS = 1024;
    localparam int unsigned FRAME_MAX_ROWS = 4096;

    // tan of 22, 23, 67 and 68 degrees in unsigned Q32
    localparam logic [63:0] TAN_22DEG = 64'd1735279427;
    localparam logic [63:0] TAN_23DEG = 64'd1823105454;
    localparam logic [63:0] TAN_67DEG = 64'd10118308865;
    localparam logic [63:0] TAN_68DEG = 64'd10630417090;

    logic [7:0]  upper_row [FRAME_MAX_COLS];
    logic [7:0]  middle_row [FRAME_MAX_COLS];
    logic [7:0]  win [6];
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned width_setting;
    int unsigned height_setting;
    result_t     expected_results [$];

    initial begin
        foreach (upper_row[i]) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        mismatch_count  = 0;
        pending_results = 0;
    end

    function automatic int unsigned clamp_dim(input int unsigned value, input int unsigned hi);
        if (value < MIN_DIM) return MIN_DIM;
        if (value > hi) return hi;
        return value;
    endfunction

    function automatic dir_t gradient_direction(input int gx, input int gy);
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] scaled;
        dir_t        diag;

        ax     = (gx < 0) ? -gx : gx;
        ay     = (gy < 0) ? -gy : gy;
        scaled = ay << 32;
        diag   = ((gx > 0) == (gy > 0)) ? DIR_DIAG_SAME : DIR_DIAG_OPPOSITE;
        if (ax == 0) return (ay == 0) ? DIR_HORIZONTAL : DIR_VERTICAL;
        // truncation toward zero makes the bounds open on one side and closed on the other
        if (gx > 0) begin
            if (scaled < TAN_23DEG * ax) return DIR_HORIZONTAL;
            if (scaled < TAN_68DEG * ax) return diag;
            return DIR_VERTICAL;
        end
        if (scaled <= TAN_22DEG * ax) return DIR_HORIZONTAL;
        if (scaled <= TAN_67DEG * ax) return diag;
        return DIR_VERTICAL;
    endfunction

    function automatic result_t make_result(input logic [20:0] mag, input dir_t dir,
                                            input int unsigned row, input int unsigned col);
        result_t res;

        res.magnitude_sq = mag;
        res.direction    = dir;
        res.out_row      = row[11:0];
        res.out_col      = col[9:0];
        res.last         = 1'b0;
        return res;
    endfunction

    function automatic void predict_pixel(input logic [23:0] px);
        int unsigned cols;
        int unsigned rows;
        int unsigned c;
        int unsigned r;
        int unsigned gray;
        int          gx;
        int          gy;
        logic [7:0]  above;
        logic [7:0]  centre;
        logic [7:0]  below;
        logic [20:0] mag;
        dir_t        dir;
        result_t     batch [$];

        cols = clamp_dim(width_setting, FRAME_MAX_COLS);
        rows = clamp_dim(height_setting, FRAME_MAX_ROWS);
        c    = col_pos;
        r    = row_pos;
        if (c >= cols || r >= rows) begin
            c = 0;
            r = 0;
        end
        gray   = (int'(px[7:0]) + int'(px[15:8]) + int'(px[23:16])) / 3;
        above  = upper_row[c];
        centre = middle_row[c];
        below  = gray[7:0];

        if (r >= 1 && c >= 1) begin
            mag = '0;
            dir = DIR_HORIZONTAL;
            if (r >= 2 && c >= 2) begin
                gx = -int'(win[0]) - 2 * int'(win[1]) - int'(win[2])
                     + int'(above) + 2 * int'(centre) + int'(below);
                gy = -int'(win[0]) - 2 * int'(win[3]) - int'(above)
                     + int'(win[2]) + 2 * int'(win[5]) + int'(below);
                mag = 21'(gx * gx + gy * gy);
                dir = gradient_direction(gx, gy);
            end
            batch = {batch, make_result(mag, dir, r - 1, c - 1)};
        end
        if (r >= 1 && c == cols - 1) batch = {batch, make_result('0, DIR_HORIZONTAL, r - 1, c)};
        if (r == rows - 1) batch = {batch, make_result('0, DIR_HORIZONTAL, r, c)};
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        expected_results = {expected_results, batch};

        // advance the window by one column and refresh the line stores
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = above;
        win[4] = centre;
        win[5] = below;
        upper_row[c]  = centre;
        middle_row[c] = below;

        c++;
        if (c >= cols) begin
            c = 0;
            r++;
            if (r >= rows) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_result(input logic [47:0] data, input logic last);
        result_t want;

        if (expected_results.size() == 0) begin
            $error("result with none expected: row %0d col %0d", data[34:23], data[44:35]);
            mismatch_count++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("magnitude_sq", want.magnitude_sq, data[20:0]);
        compare_field("direction", want.direction, data[22:21]);
        compare_field("out_row", want.out_row, data[34:23]);
        compare_field("out_col", want.out_col, data[44:35]);
        compare_field("pad", '0, data[47:45]);
        compare_field("last", want.last, last);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (win[i]) win[i] = '0;
            col_pos        = 0;
            row_pos        = 0;
            width_setting  = RESET_WIDTH;
            height_setting = RESET_HEIGHT;
            expected_results.delete();
        end else begin
            // a register write restarts the frame
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_FRAME_WIDTH) begin
                    width_setting = cfg_data[10:0];
                end else begin
                    height_setting = cfg_data;
                end
                col_pos = 0;
                row_pos = 0;
            end
            if (s_tvalid && s_tready) predict_pixel(s_tdata);
            if (m_tvalid && m_tready) check_result(m_tdata, m_tlast);
        end
        pending_results = expected_results.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the Sobel gradient stream unit testbench: clock, reset, frame size writes,
// pixel stimulus and output backpressure; sgs_checker does all the checking.
// Depends on sgs_pkg, sobel_gradient_stream_unit and sgs_checker.
`timescale 1ns / 100ps
module tb_top;
    import sgs_pkg::*;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 12;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [12:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;
    int          mismatch_count;
    int          pending_results;
    int unsigned cycle_count = 0;
    bit          steady_flow;
    int unsigned rand_cols;
    int unsigned rand_rows;

    // gray levels of a 5 x 3 frame: flat window, then two diagonal ones
    byte unsigned corner_frame [15] = '{
        8'd0, 8'd0, 8'd0, 8'd0,   8'd255,
        8'd0, 8'd0, 8'd0, 8'd0,   8'd255,
        8'd0, 8'd0, 8'd0, 8'd255, 8'd255
    };

    sobel_gradient_stream_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    sgs_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always #10 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= steady_flow || ($urandom_range(99) >= 9);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // both registers, valid held high across the two requests
    task automatic set_frame(input logic [12:0] cols, input logic [12:0] rows);
        cfg_valid <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= cols;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= rows;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // leaves s_tvalid high; the next gap or drain lowers it
    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue);
        while (!steady_flow && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {blue, green, red};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_random_pixel();
        logic [7:0] level;

        level = 8'($urandom);
        case ($urandom_range(3))
            0: send_pixel(level, level, level);
            1: begin
                level = $urandom_range(1) ? 8'hFF : 8'h00;
                send_pixel(level, level, level);
            end
            default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        endcase
    endtask

    // hold off until every expected result is in and the pipeline is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic run_frames(input logic [12:0] cols, input logic [12:0] rows,
                              input int unsigned pixels);
        set_frame(cols, rows);
        repeat (pixels) send_random_pixel();
        drain();
    endtask

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_FRAME_WIDTH;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        steady_flow = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_frame(13'd5, 13'd3);
        foreach (corner_frame[i]) begin
            send_pixel(corner_frame[i], corner_frame[i], corner_frame[i]);
        end
        drain();

        // dark top, equal-sum mixed middle, white bottom: zero gx, nonzero gy
        set_frame(13'd3, 13'd3);
        repeat (3) send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'h00, 8'h80);
        send_pixel(8'h00, 8'h80, 8'hFF);
        send_pixel(8'h80, 8'hFF, 8'h00);
        repeat (3) send_pixel(8'hFF, 8'hFF, 8'hFF);
        drain();

        // sizes below the minimum clamp to 3 x 3
        run_frames(13'd0, 13'd1, 12);

        steady_flow = 1'b1;
        run_frames(13'd6, 13'd4, 30);
        steady_flow = 1'b0;

        rand_cols = $urandom_range(9, 4);
        rand_rows = $urandom_range(5, 3);
        run_frames(13'(rand_cols), 13'(rand_rows), rand_cols * rand_rows);

        // width above the maximum clamps, start of the first row only
        run_frames(13'd2047, 13'd3, 12);
        // tallest frame, first rows only
        run_frames(13'd3, 13'd8191, 15);
        // one frame and a wrap into the next
        run_frames(13'd7, 13'd5, 39);

        if (mismatch_count == 0 && pending_results == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
